FILE: rtl/core/dtfs_pkg.sv
// ----------------------------------------------------------------------------
// dtfs_pkg
// Shared types and constants for the delimited text field splitter.
// ----------------------------------------------------------------------------
package dtfs_pkg;

  localparam int unsigned MAX_FIELD_LEN_DEF = 256;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

  localparam logic [BYTE_W-1:0] QUOTE_CHAR_RST = 8'd34;
  localparam logic [FIELD_W-1:0] FIELDS_PER_RECORD_RST = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_CHAR        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELDS_PER_RECORD = 2'd1;

  typedef enum logic [4:0] {
    PH_START  = 5'b00001,
    PH_INPUT  = 5'b00010,
    PH_QUOTED = 5'b00100,
    PH_AFTERQ = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               data_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic [FIELD_W-1:0] field_number;
    logic               field_end;
    logic               record_end;
    logic               truncated;
  } res_t;

endpackage

FILE: rtl/core/delimited_text_field_splitter.sv
// ----------------------------------------------------------------------------
// delimited_text_field_splitter
// Splits a comma-separated byte stream into quoted or plain fields.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | in_text_byte
//  out     | output    | out_valid / out_stall | data, field and end flags
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat in, one beat out; a byte is decoded in the cycle it is accepted
// and its result lands in the output register on that edge, or in the skid
// register if the output stalls, so the block sustains one byte per clock
// while the output does not stall. A skid register behind the output register
// keeps input flowing for one beat of output stall; in_stall rises only when
// the skid is occupied. Synchronous reset returns the parser to the start of a
// record and loads the register defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module delimited_text_field_splitter #(
  parameter int unsigned MaxFieldLen = dtfs_pkg::MAX_FIELD_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dtfs_pkg::BYTE_W-1:0]    in_text_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_data_valid,
  output logic [dtfs_pkg::BYTE_W-1:0]    out_data_byte,
  output logic [dtfs_pkg::FIELD_W-1:0]   out_field_number,
  output logic                           out_field_end,
  output logic                           out_record_end,
  output logic                           out_truncated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dtfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtfs_pkg::BYTE_W-1:0]    cfg_data
);

  logic [dtfs_pkg::BYTE_W-1:0]  quote_r;
  logic [dtfs_pkg::FIELD_W-1:0] fpr_r;

  logic           in_acc;
  dtfs_pkg::res_t step_res;

  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;
  dtfs_pkg::res_t out_r, out_nxt;
  dtfs_pkg::res_t skid_r, skid_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= dtfs_pkg::QUOTE_CHAR_RST;
      fpr_r   <= dtfs_pkg::FIELDS_PER_RECORD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dtfs_pkg::REG_QUOTE_CHAR:        quote_r <= cfg_data;
        dtfs_pkg::REG_FIELDS_PER_RECORD: fpr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  dtfs_parse #(
    .MaxFieldLen (MaxFieldLen)
  ) u_parse (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_en           (in_acc),
    .text_byte         (in_text_byte),
    .quote_char        (quote_r),
    .fields_per_record (fpr_r),
    .res               (step_res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || !out_stall) begin
      // advance: skid beat goes first, else the fresh one
      out_valid_nxt  = skid_valid_r || in_acc;
      out_nxt        = skid_valid_r ? skid_r : step_res;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      // hold the output, park the new beat
      skid_valid_nxt = 1'b1;
      skid_nxt       = step_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_data_valid   = out_r.data_valid;
  assign out_data_byte    = out_r.data_byte;
  assign out_field_number = out_r.field_number;
  assign out_field_end    = out_r.field_end;
  assign out_record_end   = out_r.record_end;
  assign out_truncated    = out_r.truncated;

endmodule

FILE: rtl/core/dtfs_parse.sv
// ----------------------------------------------------------------------------
// dtfs_parse
// Parser state and per-byte decode: one byte in, one result out, same cycle.
// ----------------------------------------------------------------------------
module dtfs_parse #(
  parameter int unsigned MaxFieldLen = dtfs_pkg::MAX_FIELD_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [dtfs_pkg::BYTE_W-1:0]  text_byte,
  input  logic [dtfs_pkg::BYTE_W-1:0]  quote_char,
  input  logic [dtfs_pkg::FIELD_W-1:0] fields_per_record,
  output dtfs_pkg::res_t               res
);

  localparam int unsigned CntW = $clog2(MaxFieldLen + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxFieldLen);

  dtfs_pkg::phase_t             phase_r, phase_nxt;
  logic [dtfs_pkg::FIELD_W-1:0] field_r, field_nxt;
  logic [CntW-1:0]              count_r, count_nxt;

  logic [dtfs_pkg::FIELD_W-1:0] fpr;
  logic [dtfs_pkg::FIELD_W:0]   field_inc;
  logic store, keep, fend, rend, trunc;

  always_comb begin
    fpr       = (fields_per_record == '0) ? dtfs_pkg::FIELD_W'(1) : fields_per_record;
    field_inc = {1'b0, field_r} + {{dtfs_pkg::FIELD_W{1'b0}}, 1'b1};
    phase_nxt = phase_r;
    field_nxt = field_r;
    count_nxt = count_r;
    store = 1'b0;
    fend  = 1'b0;
    rend  = 1'b0;
    trunc = 1'b0;
    keep  = 1'b0;

    if (phase_r == dtfs_pkg::PH_SKIP) begin
      rend = (text_byte == dtfs_pkg::CH_NEWLINE);
    end else if (text_byte == quote_char) begin
      case (phase_r)
        dtfs_pkg::PH_START:  phase_nxt = dtfs_pkg::PH_QUOTED;
        dtfs_pkg::PH_QUOTED: phase_nxt = dtfs_pkg::PH_AFTERQ;
        default:             store = 1'b1;
      endcase
    end else if (text_byte == dtfs_pkg::CH_COMMA && quote_char != '0) begin
      if (phase_r == dtfs_pkg::PH_QUOTED) store = 1'b1;
      else                                fend  = 1'b1;
    end else if (text_byte == dtfs_pkg::CH_NEWLINE) begin
      fend = 1'b1;
      rend = 1'b1;
    end else if (phase_r != dtfs_pkg::PH_AFTERQ) begin
      if (phase_r == dtfs_pkg::PH_START) phase_nxt = dtfs_pkg::PH_INPUT;
      store = 1'b1;
    end

    // drop content once the field is full
    if (store) begin
      if (count_r < CntMax) begin
        count_nxt = count_r + CntW'(1);
        keep      = 1'b1;
      end else begin
        trunc = 1'b1;
      end
    end

    if (rend) begin
      phase_nxt = dtfs_pkg::PH_START;
      field_nxt = '0;
      count_nxt = '0;
    end else if (fend) begin
      count_nxt = '0;
      if (field_inc >= {1'b0, fpr}) begin
        phase_nxt = dtfs_pkg::PH_SKIP;
      end else begin
        field_nxt = field_inc[dtfs_pkg::FIELD_W-1:0];
        phase_nxt = dtfs_pkg::PH_START;
      end
    end

    res.data_valid   = keep;
    res.data_byte    = keep ? text_byte : '0;
    res.field_number = field_r;
    res.field_end    = fend;
    res.record_end   = rend;
    res.truncated    = trunc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtfs_pkg::PH_START;
      field_r <= '0;
      count_r <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
